/* sv/bsd_pkg.sv */
// shared types and constants for the backslash escape decoder
package bsd_pkg;

   // longest count that out_length may report before it saturates
   localparam longint unsigned MAX_LENGTH = 64'd65535;
   localparam logic [16:0] COUNT_CAP =
      (MAX_LENGTH > 64'd65535) ? 17'd65535 : 17'(MAX_LENGTH);

   // default number of bundle slots between front and back
   localparam int QUEUE_DEPTH_DEF = 4;

   // characters that the parser looks for
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_DQUOTE    = 8'h22;
   localparam logic [7:0] CH_SQUOTE    = 8'h27;
   localparam logic [7:0] CH_LOWER_R   = 8'h72;
   localparam logic [7:0] CH_LOWER_N   = 8'h6E;
   localparam logic [7:0] CH_LOWER_T   = 8'h74;
   localparam logic [7:0] CH_LOWER_X   = 8'h78;
   localparam logic [7:0] CH_UPPER_X   = 8'h58;
   localparam logic [7:0] CH_ZERO      = 8'h30;
   localparam logic [7:0] CH_NINE      = 8'h39;
   localparam logic [7:0] CH_LOWER_A   = 8'h61;
   localparam logic [7:0] CH_LOWER_F   = 8'h66;
   localparam logic [7:0] CH_UPPER_A   = 8'h41;
   localparam logic [7:0] CH_UPPER_F   = 8'h46;

   // decoded control characters
   localparam logic [7:0] BYTE_CR  = 8'h0D;
   localparam logic [7:0] BYTE_LF  = 8'h0A;
   localparam logic [7:0] BYTE_TAB = 8'h09;
   localparam logic [7:0] BYTE_NUL = 8'h00;

   // at most three decoded bytes per source character
   localparam int BURST_MAX = 3;

   typedef enum logic [1:0] {
      PH_TEXT = 2'd0,
      PH_BSL  = 2'd1,
      PH_X    = 2'd2,
      PH_XD   = 2'd3
   } parse_phase_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_string;
   } req_word_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        run_last;
      logic        string_done;
      logic [15:0] out_length;
   } rsp_word_type;

   // decoded bytes of one source character, as queued for the back end
   typedef struct packed {
      logic [BURST_MAX-1:0][7:0] bytes;
      logic [1:0]                nbytes;
      logic                      eos;
      logic [15:0]               length;
   } bundle_type;

endpackage

/* sv/backslash_escape_decoder.sv */
// top level of the backslash escape decoder
// Decodes a C-style escaped string arriving one character per req word and
// returns the decoded bytes one per rsp word, with run_last on the last byte
// of each character and string_done plus out_length on the last byte of the
// string. The parser takes a new character every cycle while its bundle
// queue (QUEUE_DEPTH entries) has room; the serializer sends one byte per
// cycle while rsp_ready is high; a character that decodes to k bytes (zero to
// three) takes k result words, and with rsp_ready high the sustained rate is
// one character per cycle whenever the decoded stream averages at most one
// byte per character.
module backslash_escape_decoder
   import bsd_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_word_type rsp_word
);

   logic       push;
   bundle_type push_data;
   logic       queue_full;
   logic       pop;
   bundle_type head_data;
   logic       head_valid;

   // parser
   bsd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_word   (req_word),
      .push       (push),
      .push_data  (push_data),
      .queue_full (queue_full)
   );

   // bundle queue
   bsd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .full       (queue_full),
      .pop        (pop),
      .head_data  (head_data),
      .head_valid (head_valid)
   );

   // byte serializer
   bsd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_data  (head_data),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_word   (rsp_word)
   );

endmodule

/* sv/bsd_front.sv */
// parser: classifies each source character and builds a bundle of decoded bytes
module bsd_front
   import bsd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_word_type req_word,
   output logic         push,
   output bundle_type   push_data,
   input  logic         queue_full
);

   parse_phase_type phase_ff, phase_in;
   logic [7:0]      x_letter_ff, x_letter_in;
   logic [7:0]      first_digit_ff, first_digit_in;
   logic [15:0]     count_ff, count_in;

   bundle_type      bundle;
   parse_phase_type phase_mid;
   logic            do_plain;
   logic [16:0]     count_sum;
   logic [15:0]     count_new;
   logic            accept;
   logic [7:0]      b;

   function automatic logic is_hex(input logic [7:0] c);
      return (c >= CH_ZERO && c <= CH_NINE) ||
             (c >= CH_LOWER_A && c <= CH_LOWER_F) ||
             (c >= CH_UPPER_A && c <= CH_UPPER_F);
   endfunction

   function automatic logic [3:0] hex_val(input logic [7:0] c);
      logic [3:0] v;
      v = 4'd0;
      if (c >= CH_ZERO && c <= CH_NINE) begin
         v = 4'(c - CH_ZERO);
      end else if (c >= CH_LOWER_A && c <= CH_LOWER_F) begin
         v = 4'(c - CH_LOWER_A + 8'd10);
      end else if (c >= CH_UPPER_A && c <= CH_UPPER_F) begin
         v = 4'(c - CH_UPPER_A + 8'd10);
      end
      return v;
   endfunction

   // append one byte to the bundle
   function automatic bundle_type add_byte(input bundle_type bn, input logic [7:0] v);
      bundle_type r;
      r = bn;
      if (r.nbytes != 2'(BURST_MAX)) begin
         r.bytes[r.nbytes] = v;
         r.nbytes          = r.nbytes + 2'd1;
      end
      return r;
   endfunction

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;
   assign b         = req_word.in_byte;

   // decode one character against the parse phase
   always_comb begin
      bundle         = '0;
      phase_mid      = phase_ff;
      x_letter_in    = x_letter_ff;
      first_digit_in = first_digit_ff;
      do_plain       = 1'b0;

      case (phase_ff)
         PH_BSL: begin
            phase_mid = PH_TEXT;
            case (b)
               CH_LOWER_R:   bundle = add_byte(bundle, BYTE_CR);
               CH_LOWER_N:   bundle = add_byte(bundle, BYTE_LF);
               CH_LOWER_T:   bundle = add_byte(bundle, BYTE_TAB);
               CH_BACKSLASH: bundle = add_byte(bundle, b);
               CH_DQUOTE:    bundle = add_byte(bundle, b);
               CH_SQUOTE:    bundle = add_byte(bundle, b);
               CH_ZERO:      bundle = add_byte(bundle, BYTE_NUL);
               CH_LOWER_X, CH_UPPER_X: begin
                  x_letter_in = b;
                  phase_mid   = PH_X;
               end
               default: begin
                  bundle = add_byte(bundle, CH_BACKSLASH);
                  bundle = add_byte(bundle, b);
               end
            endcase
         end
         PH_X: begin
            if (is_hex(b)) begin
               first_digit_in = b;
               phase_mid      = PH_XD;
            end else begin
               bundle    = add_byte(bundle, x_letter_ff);
               phase_mid = PH_TEXT;
               do_plain  = 1'b1;
            end
         end
         PH_XD: begin
            phase_mid = PH_TEXT;
            if (is_hex(b)) begin
               bundle = add_byte(bundle, {hex_val(first_digit_ff), hex_val(b)});
            end else begin
               bundle   = add_byte(bundle, x_letter_ff);
               bundle   = add_byte(bundle, first_digit_ff);
               do_plain = 1'b1;
            end
         end
         default: begin
            phase_mid = PH_TEXT;
            do_plain  = 1'b1;
         end
      endcase

      // ordinary text, which may open a new escape
      if (do_plain) begin
         if (b == CH_BACKSLASH) begin
            phase_mid = PH_BSL;
         end else begin
            bundle = add_byte(bundle, b);
         end
      end

      // end of string flushes whatever escape is still open
      if (req_word.end_of_string) begin
         case (phase_mid)
            PH_BSL:  bundle = add_byte(bundle, CH_BACKSLASH);
            PH_X:    bundle = add_byte(bundle, x_letter_in);
            PH_XD: begin
               bundle = add_byte(bundle, x_letter_in);
               bundle = add_byte(bundle, first_digit_in);
            end
            default: bundle = bundle;
         endcase
      end

      // saturating byte count
      count_sum = {1'b0, count_ff} + 17'(bundle.nbytes);
      count_new = (count_sum > COUNT_CAP) ? COUNT_CAP[15:0] : count_sum[15:0];

      bundle.eos    = req_word.end_of_string;
      bundle.length = count_new;

      // state update, cleared at the end of each string
      phase_in = phase_ff;
      count_in = count_ff;
      if (accept) begin
         if (req_word.end_of_string) begin
            phase_in       = PH_TEXT;
            x_letter_in    = '0;
            first_digit_in = '0;
            count_in       = '0;
         end else begin
            phase_in = phase_mid;
            count_in = count_new;
         end
      end else begin
         x_letter_in    = x_letter_ff;
         first_digit_in = first_digit_ff;
      end
   end

   assign push      = accept && (bundle.nbytes != 2'd0);
   assign push_data = bundle;

   // parse state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_TEXT;
         x_letter_ff    <= '0;
         first_digit_ff <= '0;
         count_ff       <= '0;
      end else begin
         phase_ff       <= phase_in;
         x_letter_ff    <= x_letter_in;
         first_digit_ff <= first_digit_in;
         count_ff       <= count_in;
      end
   end

   // a final character always leaves the parser clean
   a_eos_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && req_word.end_of_string) |=> (phase_ff == PH_TEXT && count_ff == 16'd0))
      else $error("parser state not cleared after end of string");

   // a final character always produces at least one byte
   a_eos_pushes: assert property (@(posedge clock) disable iff (reset)
      (accept && req_word.end_of_string) |-> push)
      else $error("end of string produced no bundle");

endmodule

/* sv/bsd_queue.sv */
// small bundle queue between the parser and the byte serializer
module bsd_queue
   import bsd_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  bundle_type push_data,
   output logic       full,
   input  logic       pop,
   output bundle_type head_data,
   output logic       head_valid
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   bundle_type          slot_ff [DEPTH];
   logic [AW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]       fill_ff, fill_in;
   logic                do_push, do_pop;

   assign full       = (fill_ff == CW'(DEPTH));
   assign head_valid = (fill_ff != '0);
   assign head_data  = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // slot storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   // a push against a full queue would lose a bundle
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("push into full queue");

endmodule

/* sv/bsd_back.sv */
// serializer: sends the bytes of each queued bundle one word at a time
module bsd_back
   import bsd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         head_valid,
   input  bundle_type   head_data,
   output logic         pop,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_word_type rsp_word
);

   logic [1:0]   idx_ff, idx_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_word_ff, rsp_word_in;
   logic         load;
   logic         last;

   assign load = head_valid && (!rsp_valid_ff || rsp_ready);
   assign last = (idx_ff == head_data.nbytes - 2'd1);
   assign pop  = load && last;

   // pick the next byte of the head bundle
   always_comb begin
      rsp_word_in  = rsp_word_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (load) begin
         rsp_word_in.out_byte    = head_data.bytes[idx_ff];
         rsp_word_in.run_last    = last;
         rsp_word_in.string_done = last && head_data.eos;
         rsp_word_in.out_length  = (last && head_data.eos) ? head_data.length : '0;
         rsp_valid_in            = 1'b1;
         idx_in                  = last ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // output word register
   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // the end of a string is always the end of its character's run
   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_word_ff.string_done) |-> rsp_word_ff.run_last)
      else $error("string_done without run_last");

   // a length is reported only on the final word of a string
   a_length_only_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_word_ff.string_done) |-> (rsp_word_ff.out_length == 16'd0))
      else $error("out_length set on a word that does not end the string");

endmodule

/* verif/testbench.sv */
// self-checking testbench for the backslash escape decoder
`timescale 1ns / 100ps

module testbench;
   import bsd_pkg::*;

   localparam int SQUEEZE_AT     = 30;    // words sent before the long result stall
   localparam int SQUEEZE_SPAN   = 300;
   localparam int DRAIN_CYCLES   = 16;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int RANDOM_WORDS   = 130;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_word_type req_word  = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_word_type rsp_word;

   backslash_escape_decoder u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   always #4 clock = ~clock;

   // source characters waiting to go out, decoded bytes waiting to come back
   req_word_type    pending_q[$];
   rsp_word_type    decoded_q[$];
   int              sent_count   = 0;
   int              errors       = 0;
   int              gap_left     = 0;
   int              hold_left    = 0;
   int              idle_cycles  = 0;
   bit              squeeze_done = 1'b0;

   // decoder state as predicted
   parse_phase_type phase      = PH_TEXT;
   logic [7:0]      x_char     = 8'h00;
   logic [7:0]      digit_char = 8'h00;
   logic [15:0]     byte_count = 16'h0000;
   logic [7:0]      burst[BURST_MAX];
   int              burst_n    = 0;

   function automatic int idle_span();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(12, 40);
   endfunction

   function automatic bit hex_digit_ok(input logic [7:0] c);
      return (c >= CH_ZERO && c <= CH_NINE) || (c >= CH_LOWER_A && c <= CH_LOWER_F) ||
             (c >= CH_UPPER_A && c <= CH_UPPER_F);
   endfunction

   function automatic logic [3:0] hex_nibble(input logic [7:0] c);
      if (c >= CH_ZERO && c <= CH_NINE) return 4'(c - CH_ZERO);
      if (c >= CH_LOWER_A && c <= CH_LOWER_F) return 4'(c - CH_LOWER_A + 8'd10);
      return 4'(c - CH_UPPER_A + 8'd10);
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want_v);
      $display("%0t: %s got %0h want %0h", $realtime, what, got, want_v);
      errors++;
   endtask

   // one decoded byte: into the burst, and counted up to the cap
   task automatic add_byte(input logic [7:0] b);
      if (burst_n < BURST_MAX) begin
         burst[burst_n] = b;
         burst_n++;
      end
      if ({1'b0, byte_count} < COUNT_CAP) byte_count++;
   endtask

   // character seen as ordinary text
   task automatic take_text(input logic [7:0] b);
      if (b == CH_BACKSLASH) phase = PH_BSL;
      else add_byte(b);
   endtask

   // advance the predicted state by one source character, queue its bytes
   task automatic decode_char(input req_word_type w);
      logic [7:0]   b;
      logic         eos;
      rsp_word_type r;
      b       = w.in_byte;
      eos     = w.end_of_string;
      burst_n = 0;
      case (phase)
         PH_BSL: begin
            phase = PH_TEXT;
            case (b)
               CH_LOWER_R: add_byte(BYTE_CR);
               CH_LOWER_N: add_byte(BYTE_LF);
               CH_LOWER_T: add_byte(BYTE_TAB);
               CH_BACKSLASH, CH_DQUOTE, CH_SQUOTE: add_byte(b);
               CH_ZERO: add_byte(BYTE_NUL);
               CH_LOWER_X, CH_UPPER_X: begin
                  x_char = b;
                  phase  = PH_X;
               end
               default: begin
                  add_byte(CH_BACKSLASH);
                  add_byte(b);
               end
            endcase
         end
         PH_X: begin
            if (hex_digit_ok(b)) begin
               digit_char = b;
               phase      = PH_XD;
            end else begin
               add_byte(x_char);
               phase = PH_TEXT;
               take_text(b);
            end
         end
         PH_XD: begin
            phase = PH_TEXT;
            if (hex_digit_ok(b)) begin
               add_byte({hex_nibble(digit_char), hex_nibble(b)});
            end else begin
               add_byte(x_char);
               add_byte(digit_char);
               take_text(b);
            end
         end
         default: take_text(b);
      endcase
      // flush an open escape at the end of the string
      if (eos) begin
         case (phase)
            PH_BSL: add_byte(CH_BACKSLASH);
            PH_X: add_byte(x_char);
            PH_XD: begin
               add_byte(x_char);
               add_byte(digit_char);
            end
            default: ;
         endcase
      end
      for (int k = 0; k < burst_n; k++) begin
         r.out_byte    = burst[k];
         r.run_last    = (k == burst_n - 1);
         r.string_done = (k == burst_n - 1) && eos;
         r.out_length  = r.string_done ? byte_count : 16'h0000;
         decoded_q.push_back(r);
      end
      if (eos) begin
         phase      = PH_TEXT;
         x_char     = 8'h00;
         digit_char = 8'h00;
         byte_count = 16'h0000;
      end
   endtask

   // driver: offers pending characters, predicts each one as it is taken
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left  <= 0;
      end else begin
         if (req_valid && req_ready) begin
            decode_char(req_word);
            sent_count <= sent_count + 1;
         end
         if (!req_valid || req_ready) begin
            if (gap_left != 0) begin
               gap_left  <= gap_left - 1;
               req_valid <= 1'b0;
            end else if (pending_q.size() != 0) begin
               req_word  <= pending_q.pop_front();
               req_valid <= 1'b1;
               gap_left  <= idle_span();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver: random stalls, plus one long hold-off to back up the input
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left <= 0;
      end else if (!squeeze_done && sent_count >= SQUEEZE_AT) begin
         squeeze_done <= 1'b1;
         hold_left    <= SQUEEZE_SPAN;
         rsp_ready    <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         hold_left <= idle_span();
      end
   end

   // monitor: each result word against the oldest predicted byte
   always @(posedge clock) begin : monitor
      rsp_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (decoded_q.size() == 0) begin
            report_mismatch("unexpected word, out_byte", 32'(rsp_word.out_byte), 32'd0);
         end else begin
            want = decoded_q.pop_front();
            if (rsp_word.out_byte !== want.out_byte)
               report_mismatch("out_byte", 32'(rsp_word.out_byte), 32'(want.out_byte));
            if (rsp_word.run_last !== want.run_last)
               report_mismatch("run_last", 32'(rsp_word.run_last), 32'(want.run_last));
            if (rsp_word.string_done !== want.string_done)
               report_mismatch("string_done", 32'(rsp_word.string_done),
                               32'(want.string_done));
            if (rsp_word.out_length !== want.out_length)
               report_mismatch("out_length", 32'(rsp_word.out_length),
                               32'(want.out_length));
         end
      end
   end

   // watchdog on cycles with no word moving on either side
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $realtime, idle_cycles);
         $display("[backslash_escape_decoder] ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic push_char(input logic [7:0] b, input logic eos);
      req_word_type w;
      w.in_byte       = b;
      w.end_of_string = eos;
      pending_q.push_back(w);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) push_char(s[i], i == s.len() - 1);
   endtask

   function automatic logic [7:0] rand_hex();
      int d;
      d = $urandom_range(0, 21);
      if (d < 10) return CH_ZERO + 8'(d);
      if (d < 16) return CH_LOWER_A + 8'(d - 10);
      return CH_UPPER_A + 8'(d - 16);
   endfunction

   function automatic logic [7:0] rand_x();
      return $urandom_range(0, 1) ? CH_UPPER_X : CH_LOWER_X;
   endfunction

   // one random string, mostly plain text and well-formed escapes with random content
   task automatic build_string();
      logic [7:0] chars[$];
      logic [7:0] b;
      int         tokens;
      int         r;
      tokens = $urandom_range(1, 8);
      for (int t = 0; t < tokens; t++) begin
         r = $urandom_range(0, 99);
         if (r < 35) begin
            b = 8'($urandom_range(0, 255));
            if (b == CH_BACKSLASH) b = CH_UPPER_A;
            chars.push_back(b);
         end else if (r < 55) begin
            chars.push_back(CH_BACKSLASH);
            case ($urandom_range(0, 6))
               0: chars.push_back(CH_LOWER_R);
               1: chars.push_back(CH_LOWER_N);
               2: chars.push_back(CH_LOWER_T);
               3: chars.push_back(CH_BACKSLASH);
               4: chars.push_back(CH_DQUOTE);
               5: chars.push_back(CH_SQUOTE);
               default: chars.push_back(CH_ZERO);
            endcase
         end else if (r < 72) begin
            chars.push_back(CH_BACKSLASH);
            chars.push_back(rand_x());
            chars.push_back(rand_hex());
            chars.push_back(rand_hex());
         end else if (r < 82) begin
            // hex escape broken by a non-digit, possibly a new backslash
            chars.push_back(CH_BACKSLASH);
            chars.push_back(rand_x());
            if ($urandom_range(0, 1)) chars.push_back(rand_hex());
            if ($urandom_range(0, 3) == 0) begin
               b = CH_BACKSLASH;
            end else begin
               b = 8'($urandom_range(0, 255));
               while (hex_digit_ok(b)) b = 8'($urandom_range(0, 255));
            end
            chars.push_back(b);
         end else if (r < 92) begin
            chars.push_back(CH_BACKSLASH);
            chars.push_back(8'($urandom_range(0, 255)));
         end else begin
            chars.push_back(8'($urandom_range(0, 255)));
         end
      end
      // sometimes leave an escape open at the end
      r = $urandom_range(0, 99);
      if (r < 12) begin
         chars.push_back(CH_BACKSLASH);
      end else if (r < 20) begin
         chars.push_back(CH_BACKSLASH);
         chars.push_back(rand_x());
      end else if (r < 28) begin
         chars.push_back(CH_BACKSLASH);
         chars.push_back(rand_x());
         chars.push_back(rand_hex());
      end
      foreach (chars[i]) push_char(chars[i], i == chars.size() - 1);
   endtask

   initial begin
      int  random_words;
      int  mark;
      random_words = 0;

      // directed: byte extremes, every escape, hex, and open escapes at the end
      push_char(8'h00, 1'b0);
      push_char(8'hFF, 1'b1);
      send_text("\\r\\n\\t\\\\\\\"\\'\\0");
      send_text("\\XaF");
      send_text("\\");
      send_text("\\X");
      send_text("\\xf");

      // random strings
      while (random_words < RANDOM_WORDS) begin
         mark = pending_q.size();
         build_string();
         random_words += pending_q.size() - mark;
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (pending_q.size() != 0 || req_valid || decoded_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (errors == 0) begin
         $display("[backslash_escape_decoder] OK");
      end else begin
         $display("[backslash_escape_decoder] ERROR");
      end
      $finish;
   end

endmodule

/* files.f */
sv/bsd_pkg.sv
sv/bsd_front.sv
sv/bsd_queue.sv
sv/bsd_back.sv
sv/backslash_escape_decoder.sv
verif/testbench.sv
